FILE: rtl/dsfp_pkg.sv
// shared types and constants for the dust sensor frame parser
`default_nettype none

package dsfp_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned GAIN_W = 16;
	localparam int unsigned RAW_W = 16;
	localparam int unsigned VOLT_W = 19;
	localparam int unsigned DUST_W = 35;
	localparam int unsigned POS_W = 3;
	localparam int unsigned FRAME_LEN = 5;

	localparam logic [BYTE_W-1:0] BYTE_SOF = 8'hAA;
	localparam logic [BYTE_W-1:0] BYTE_EOF = 8'hFF;
	localparam logic [POS_W-1:0] POS_IDLE = 3'd0;
	localparam logic [POS_W-1:0] POS_FIRST = 3'd1;
	localparam logic [POS_W-1:0] POS_MAX = 3'd6;
	localparam logic [GAIN_W-1:0] DUST_GAIN_RESET = 16'd800;
	// 999 * 1024
	localparam logic [DUST_W-1:0] FAIL_DUST_Q10 = 35'd1022976;

	typedef struct packed {
		logic [FRAME_LEN-1:0][BYTE_W-1:0] bytes;
	} frame_t;

	typedef struct packed {
		logic checksum_ok;
		logic [RAW_W-1:0] raw_reading;
		logic [VOLT_W-1:0] voltage_q10;
		logic [DUST_W-1:0] dust_q10;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/dust_sensor_frame_parser_unit.sv
// top level of the dust sensor frame parser
//
// channel | direction | handshake           | payload
// --------+-----------+---------------------+---------------------------------------------
// cfg     | in        | cfg_valid/cfg_ready | cfg_data (dust_gain)
// in      | in        | in_valid/in_ready   | rx_byte
// out     | out       | out_valid/out_ready | checksum_ok, raw_reading, voltage_q10, dust_q10
//
// one byte per cycle while in_ready is high; an end-of-frame byte's result is registered in
// one stage for the frame snapshot and one for checksum and the 19x16 multiply
// reset clears frame position, stored bytes, stage valids and sets the gain to 800
// in_ready drops only while both the frame stage and the result register are full
// and out_ready is low; cfg_ready is always high
`default_nettype none

module dust_sensor_frame_parser_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [7:0]  rx_byte,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic        checksum_ok,
	output      logic [15:0] raw_reading,
	output      logic [18:0] voltage_q10,
	output      logic [34:0] dust_q10
);

	logic [dsfp_pkg::GAIN_W-1:0] gain_q;
	logic in_accept;
	logic frame_end;
	dsfp_pkg::frame_t frame;
	dsfp_pkg::result_t result;

	assign cfg_ready = 1'b1;
	assign in_accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= dsfp_pkg::DUST_GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			gain_q <= cfg_data;
		end
	end

	dsfp_frame_capture u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_accept),
		.rx_byte   (rx_byte),
		.frame_end (frame_end),
		.frame     (frame)
	);

	dsfp_result_calc u_calc (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (in_valid && frame_end),
		.frame        (frame),
		.dust_gain    (gain_q),
		.frame_ready  (in_ready),
		.result_valid (out_valid),
		.result_ready (out_ready),
		.result       (result)
	);

	assign checksum_ok = result.checksum_ok;
	assign raw_reading = result.raw_reading;
	assign voltage_q10 = result.voltage_q10;
	assign dust_q10 = result.dust_q10;

	// a failed checksum always carries the fixed fallback values
	a_fail_values: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !checksum_ok |-> voltage_q10 == '0 && dust_q10 == dsfp_pkg::FAIL_DUST_Q10)
		else $error("checksum failure without fallback values");

	// a good result shows the voltage as five times the raw reading
	a_volt_scale: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && checksum_ok |-> voltage_q10 == (19'(raw_reading) * 19'd5))
		else $error("voltage does not match raw reading");

	// input stalls only when the result side is backed up
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with free result register");

	// an end-of-frame request has its result presented once it clears the frame stage
	a_eof_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && rx_byte == dsfp_pkg::BYTE_EOF |=> ##1 out_valid)
		else $error("end of frame lost");

endmodule

`default_nettype wire

FILE: rtl/dsfp_frame_capture.sv
// frame position tracking and byte store, with the frame snapshot at end of frame
`default_nettype none

module dsfp_frame_capture (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      accept,
	input  wire logic [dsfp_pkg::BYTE_W-1:0] rx_byte,
	output      logic                      frame_end,
	output      dsfp_pkg::frame_t          frame
);

	logic [dsfp_pkg::POS_W-1:0] pos_q;
	logic [dsfp_pkg::FRAME_LEN-1:0][dsfp_pkg::BYTE_W-1:0] bytes_q;
	logic [dsfp_pkg::FRAME_LEN-1:0][dsfp_pkg::BYTE_W-1:0] bytes_next;

	// the incoming byte lands at the current position before the frame is read
	always_comb begin
		bytes_next = bytes_q;
		for (int i = 0; i < dsfp_pkg::FRAME_LEN; i++) begin
			if (pos_q == dsfp_pkg::POS_W'(i + 1)) begin
				bytes_next[i] = rx_byte;
			end
		end
	end

	assign frame_end = (rx_byte == dsfp_pkg::BYTE_EOF);
	assign frame.bytes = bytes_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= dsfp_pkg::POS_IDLE;
			bytes_q <= '0;
		end else if (accept) begin
			bytes_q <= bytes_next;
			if (frame_end) begin
				pos_q <= dsfp_pkg::POS_IDLE;
			end else if (rx_byte == dsfp_pkg::BYTE_SOF) begin
				pos_q <= dsfp_pkg::POS_FIRST;
			end else if (pos_q < dsfp_pkg::POS_MAX) begin
				pos_q <= pos_q + dsfp_pkg::POS_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/dsfp_result_calc.sv
// frame register, checksum and scaling, result register
`default_nettype none

module dsfp_result_calc (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        frame_valid,
	input  wire dsfp_pkg::frame_t            frame,
	input  wire logic [dsfp_pkg::GAIN_W-1:0] dust_gain,
	output      logic                        frame_ready,
	output      logic                        result_valid,
	input  wire logic                        result_ready,
	output      dsfp_pkg::result_t           result
);

	logic valid_s1;
	dsfp_pkg::frame_t frame_s1;
	logic valid_s2;
	dsfp_pkg::result_t result_s2;
	dsfp_pkg::result_t result_d;

	logic adv_s2;
	logic [dsfp_pkg::BYTE_W-1:0] sum8;
	logic [dsfp_pkg::RAW_W-1:0] raw;
	logic [dsfp_pkg::VOLT_W-1:0] volt;
	logic [dsfp_pkg::DUST_W-1:0] dust;

	assign adv_s2 = !valid_s2 || result_ready;
	assign frame_ready = !valid_s1 || adv_s2;

	// bytes stored in order b1..b5 at index 0..4
	assign sum8 = frame_s1.bytes[0] + frame_s1.bytes[1] + frame_s1.bytes[2] + frame_s1.bytes[3];
	assign raw = {frame_s1.bytes[0], frame_s1.bytes[1]};
	// times five as shift and add
	assign volt = {1'b0, raw, 2'b00} + {3'b000, raw};
	assign dust = dsfp_pkg::DUST_W'(volt) * dsfp_pkg::DUST_W'(dust_gain);

	always_comb begin
		result_d.checksum_ok = (sum8 == frame_s1.bytes[4]);
		result_d.raw_reading = raw;
		if (result_d.checksum_ok) begin
			result_d.voltage_q10 = volt;
			result_d.dust_q10 = dust;
		end else begin
			result_d.voltage_q10 = '0;
			result_d.dust_q10 = dsfp_pkg::FAIL_DUST_Q10;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (frame_ready) begin
				valid_s1 <= frame_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_ready && frame_valid) begin
			frame_s1 <= frame;
		end
		if (adv_s2 && valid_s1) begin
			result_s2 <= result_d;
		end
	end

	assign result_valid = valid_s2;
	assign result = result_s2;

endmodule

`default_nettype wire
